/* hw/rtl/lsbbp_pkg.sv */
// Shared types and constants of the LSB-first bit packer.
`timescale 1ns / 1ps

package lsbbp_pkg;

	localparam int MAX_FIELD_BITS = 32;
	localparam int CODE_W         = 32;
	localparam int COUNT_W        = 6;
	localparam int BYTE_W         = 8;
	localparam int POS_W          = 3;
	localparam int MAX_BYTES      = 4;
	localparam int NBYTES_W       = 3;
	localparam int INDEX_W        = 32;
	localparam int ACC_W          = CODE_W + BYTE_W;
	localparam int IN_DATA_W      = 40;
	localparam int OUT_DATA_W     = 40;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [1:0] {
		OP_PUT_BIT  = 2'd0,
		OP_PUT_BITS = 2'd1,
		OP_ALIGN    = 2'd2,
		OP_PUT_BYTE = 2'd3
	} op_t;

	// Bytes that one item completes, the first one in the lowest bits.
	typedef struct packed {
		logic [MAX_BYTES*BYTE_W-1:0] bytes;
		logic [NBYTES_W-1:0]         nbytes;
	} job_t;

endpackage

/* hw/rtl/lsbbp_front.sv */
// Front end: accepts items, packs their bits and hands completed bytes on as jobs.
`timescale 1ns / 1ps

module lsbbp_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  lsbbp_pkg::op_t                       op,
	input  logic                                 bit_in,
	input  logic [lsbbp_pkg::CODE_W-1:0]         code_value,
	input  logic [lsbbp_pkg::COUNT_W-1:0]        bit_count,
	input  logic                                 queue_full,
	output logic                                 push,
	output lsbbp_pkg::job_t                      push_job
);

	logic [lsbbp_pkg::BYTE_W-1:0]   part_q;
	logic [lsbbp_pkg::POS_W-1:0]    pos_q;
	logic [lsbbp_pkg::BYTE_W-1:0]   part_next;
	logic [lsbbp_pkg::POS_W-1:0]    pos_next;
	logic [lsbbp_pkg::COUNT_W-1:0]  cnt_clamped;
	logic [lsbbp_pkg::CODE_W-1:0]   code_mask;
	logic [lsbbp_pkg::ACC_W-1:0]    acc;
	logic [lsbbp_pkg::COUNT_W-1:0]  total;
	logic [lsbbp_pkg::BYTE_W-1:0]   bit_set;
	logic                           accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	assign cnt_clamped = (bit_count > lsbbp_pkg::COUNT_W'(lsbbp_pkg::MAX_FIELD_BITS)) ?
		lsbbp_pkg::COUNT_W'(lsbbp_pkg::MAX_FIELD_BITS) : bit_count;
	assign code_mask = (cnt_clamped >= lsbbp_pkg::COUNT_W'(lsbbp_pkg::CODE_W)) ?
		{lsbbp_pkg::CODE_W{1'b1}} : ~({lsbbp_pkg::CODE_W{1'b1}} << cnt_clamped);
	assign acc = {{lsbbp_pkg::CODE_W{1'b0}}, part_q} |
		({{lsbbp_pkg::BYTE_W{1'b0}}, code_value & code_mask} << pos_q);
	assign total = lsbbp_pkg::COUNT_W'(pos_q) + cnt_clamped;
	// Bits at and above the write position are always zero, so an OR suffices.
	assign bit_set = part_q | (lsbbp_pkg::BYTE_W'(bit_in) << pos_q);

	always_comb begin
		part_next       = part_q;
		pos_next        = pos_q;
		push_job.bytes  = '0;
		push_job.nbytes = '0;
		unique case (op)
			lsbbp_pkg::OP_PUT_BIT: begin
				if (pos_q == {lsbbp_pkg::POS_W{1'b1}}) begin
					push_job.bytes  = {{(lsbbp_pkg::MAX_BYTES-1)*lsbbp_pkg::BYTE_W{1'b0}}, bit_set};
					push_job.nbytes = lsbbp_pkg::NBYTES_W'(1);
					part_next       = '0;
					pos_next        = '0;
				end else begin
					part_next = bit_set;
					pos_next  = pos_q + lsbbp_pkg::POS_W'(1);
				end
			end
			lsbbp_pkg::OP_PUT_BITS: begin
				// A zero count leaves total equal to the position, so nothing is emitted.
				push_job.bytes  = acc[lsbbp_pkg::MAX_BYTES*lsbbp_pkg::BYTE_W-1:0];
				push_job.nbytes = total[lsbbp_pkg::COUNT_W-1:lsbbp_pkg::POS_W];
				pos_next        = total[lsbbp_pkg::POS_W-1:0];
				case (total[lsbbp_pkg::COUNT_W-1:lsbbp_pkg::POS_W])
					3'd0:    part_next = acc[7:0];
					3'd1:    part_next = acc[15:8];
					3'd2:    part_next = acc[23:16];
					3'd3:    part_next = acc[31:24];
					default: part_next = acc[39:32];
				endcase
			end
			lsbbp_pkg::OP_ALIGN: begin
				if (pos_q != '0) begin
					push_job.bytes  = {{(lsbbp_pkg::MAX_BYTES-1)*lsbbp_pkg::BYTE_W{1'b0}}, part_q};
					push_job.nbytes = lsbbp_pkg::NBYTES_W'(1);
					part_next       = '0;
					pos_next        = '0;
				end
			end
			default: begin
				push_job.bytes  = {{(lsbbp_pkg::MAX_BYTES-1)*lsbbp_pkg::BYTE_W{1'b0}},
					code_value[lsbbp_pkg::BYTE_W-1:0]};
				push_job.nbytes = lsbbp_pkg::NBYTES_W'(1);
				part_next       = '0;
				pos_next        = '0;
			end
		endcase
	end

	assign push = accept && (push_job.nbytes != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			pos_q  <= '0;
		end else if (accept) begin
			part_q <= part_next;
			pos_q  <= pos_next;
		end
	end

endmodule

/* hw/rtl/lsbbp_queue.sv */
// Short job queue between the packing front end and the byte emitter.
`timescale 1ns / 1ps

module lsbbp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsbbp_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output lsbbp_pkg::job_t pop_job
);

	localparam int PTR_W = $clog2(lsbbp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(lsbbp_pkg::QUEUE_DEPTH + 1);

	lsbbp_pkg::job_t  mem [lsbbp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(lsbbp_pkg::QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(lsbbp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(lsbbp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(lsbbp_pkg::QUEUE_DEPTH))
		else $error("job queue holds more entries than it has");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !do_pop |-> !push)
		else $error("job written into a full queue");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue fill count missed a write");

endmodule

/* hw/rtl/lsbbp_back.sv */
// Back end: emits the bytes of each job in turn with their running stream index.
`timescale 1ns / 1ps

module lsbbp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                job_valid,
	input  lsbbp_pkg::job_t                     job,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [lsbbp_pkg::BYTE_W-1:0]        out_byte,
	output logic [lsbbp_pkg::INDEX_W-1:0]       byte_index,
	output logic                                out_last
);

	logic [lsbbp_pkg::MAX_BYTES*lsbbp_pkg::BYTE_W-1:0] cur_bytes_q;
	logic [lsbbp_pkg::NBYTES_W-1:0]                    cur_cnt_q;
	logic [lsbbp_pkg::INDEX_W-1:0]                     idx_q;
	logic                                              out_valid_q;
	logic [lsbbp_pkg::BYTE_W-1:0]                      out_byte_q;
	logic [lsbbp_pkg::INDEX_W-1:0]                     out_index_q;
	logic                                              out_last_q;
	logic                                              slot_free;
	logic                                              load;
	logic                                              cur_done;

	assign slot_free = out_ready || !out_valid_q;
	assign load      = slot_free && (cur_cnt_q != '0);
	// The current job is finished once its last byte moves into the output register.
	assign cur_done  = (cur_cnt_q == '0) ||
		(load && cur_cnt_q == lsbbp_pkg::NBYTES_W'(1));
	assign pop       = job_valid && cur_done;

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_index = out_index_q;
	assign out_last   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cnt_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_cnt_q <= job.nbytes;
			end else if (load) begin
				cur_cnt_q <= cur_cnt_q - lsbbp_pkg::NBYTES_W'(1);
			end
			if (load) begin
				idx_q       <= idx_q + lsbbp_pkg::INDEX_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_bytes_q <= job.bytes;
		end else if (load) begin
			cur_bytes_q <= cur_bytes_q >> lsbbp_pkg::BYTE_W;
		end
		if (load) begin
			out_byte_q  <= cur_bytes_q[lsbbp_pkg::BYTE_W-1:0];
			out_index_q <= idx_q;
			out_last_q  <= (cur_cnt_q == lsbbp_pkg::NBYTES_W'(1));
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_cnt_q <= lsbbp_pkg::NBYTES_W'(lsbbp_pkg::MAX_BYTES))
		else $error("current job holds more bytes than an item can complete");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && out_index_q == idx_q - lsbbp_pkg::INDEX_W'(1))
		else $error("byte index did not advance by one per emitted byte");

	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> cur_cnt_q != '0)
		else $error("empty job taken from the queue");

endmodule

/* hw/rtl/lsb_first_bit_packer.sv */
// Top level of the LSB-first bit packer: stream ports around front end, queue and emitter.
`timescale 1ns / 1ps

// Bits are packed least-significant first into bytes, and every completed byte leaves on
// the master stream with its running 32-bit stream index; the final byte that an item
// completes carries tlast. The slave side takes one item per cycle while the two-entry job
// queue has room, so items that complete no byte pass at full clock rate. The emitter
// sends one byte per cycle while the master side is ready; an item completes zero to
// four bytes, with four for a 32-bit code that straddles five byte lanes. An accepted
// item's bytes pass via the job queue and the current-job register to the output register.
module lsb_first_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // bit_in[0], code_value[32:1], bit_count[38:33], zero pad
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_byte[7:0], byte_index[39:8]
	output logic        m_axis_tlast   // last
);

	logic            queue_full;
	logic            push;
	lsbbp_pkg::job_t push_job;
	logic            pop;
	logic            pop_valid;
	lsbbp_pkg::job_t pop_job;
	logic [7:0]      out_byte;
	logic [31:0]     byte_index;

	lsbbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (lsbbp_pkg::op_t'(s_axis_tuser)),
		.bit_in     (s_axis_tdata[0]),
		.code_value (s_axis_tdata[32:1]),
		.bit_count  (s_axis_tdata[38:33]),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	lsbbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_job   (pop_job)
	);

	lsbbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (pop_valid),
		.job        (pop_job),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (out_byte),
		.byte_index (byte_index),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tdata = {byte_index, out_byte};

endmodule
